/* rtl/cmcd_pkg.sv */
package cmcd_pkg;

  localparam int GRID_Z      = 128;
  localparam int GRID_R      = 64;
  localparam int MODES       = 4;
  localparam int Z_W         = $clog2(GRID_Z);
  localparam int R_W         = $clog2(GRID_R);
  localparam int M_W         = $clog2(MODES);
  localparam int ADDR_W      = M_W + Z_W + R_W;
  localparam int DEPTH       = MODES * GRID_Z * GRID_R;
  localparam int NUM_SPECIES = 4;
  localparam int CFG_IDX_W   = $clog2(NUM_SPECIES);
  localparam int CFG_W       = 24;
  localparam int DENS_RESET  = 65536;
  localparam int DVD_W       = 48;
  localparam int DVS_W       = 24;
  localparam int DCNT_W      = $clog2(DVD_W);
  localparam int R2_W        = 48;
  localparam int ROOT_W      = R2_W / 2;
  localparam int SCNT_W      = $clog2(ROOT_W);

  localparam logic [1:0] FUNC_DEPOSIT = 2'd0;
  localparam logic [1:0] FUNC_READ    = 2'd1;
  localparam logic [1:0] FUNC_CLEAR   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SAT   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [6:0]         cell_z;
    logic [5:0]         cell_r;
    logic [1:0]         read_mode;
    logic [15:0]        z_frac;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [23:0]        particle_weight;
    logic signed [7:0]  charge;
    logic [1:0]         species;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] rho_real;
    logic signed [31:0] rho_imag;
    logic [1:0]         status;
  } out_item_t;

  function automatic logic is_sat32(input logic signed [63:0] v);
    return (v > 64'sh000000007fffffff) || (v < 64'shffffffff80000000);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sh000000007fffffff) begin
      res = 32'sh7fffffff;
    end else if (v < 64'shffffffff80000000) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic logic signed [17:0] clamp_unit(input logic signed [63:0] v);
    logic signed [17:0] res;
    if (v > 64'sd65536) begin
      res = 18'sd65536;
    end else if (v < -64'sd65536) begin
      res = -18'sd65536;
    end else begin
      res = v[17:0];
    end
    return res;
  endfunction

endpackage

/* rtl/cylindrical_modal_charge_deposit_core.sv */
// Azimuthal-mode charge deposition into two Q16.16 density stores.
// Input channel in_valid/in_ready/in_data carries one item: deposit a particle,
// read one store entry, or clear both stores. Every item gives exactly one
// result on out_valid/out_ready/out_data.
// Items are processed one at a time. A deposit passes through two squares, a
// 24-step square root, four (two on the axis) 48-step divides on one shared
// restoring divider, the mode recurrence, then 16 read-modify-write passes over
// the store memories before its result is registered. A read goes through the
// memory read register to the result; an out-of-range cell or an unused function
// goes straight to the result. A clear sweeps the memories one entry a cycle over
// all 32768 entries, then gives its result.
// After reset the same clearing pass runs with in_ready low;
// cfg writes are taken at any time.
// The result sits in an output register: the next item can be taken in the cycle after
// while it waits, and a stalled receiver only holds the block at the end of that item.
module cylindrical_modal_charge_deposit_core
  import cmcd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_P0, S_P1, S_P2, S_P3, S_SQRT, S_DLOAD, S_DIV, S_DIVEND,
    S_RECI, S_REC, S_CA, S_CT, S_RD, S_WR, S_RDA, S_RDB, S_DONE
  } state_t;

  typedef enum logic [1:0] {DIV_Q, DIV_WR, DIV_C, DIV_S} div_sel_t;

  state_t   state_r;
  div_sel_t div_sel_r;

  logic [CFG_W-1:0]   dens_r [NUM_SPECIES];
  in_item_t           item_r;
  logic               out_valid_r;
  out_item_t          out_data_r;
  logic signed [31:0] res_re_r, res_im_r;
  logic [1:0]         res_st_r;
  logic               clr_res_r;
  logic [ADDR_W-1:0]  clr_cnt_r;
  logic               flag_r;

  logic [R2_W-1:0]    r2_r;
  logic [31:0]        w_r;
  logic signed [40:0] wch_r;
  logic [R2_W-1:0]    sq_src_r;
  logic [ROOT_W+1:0]  sq_rem_r;
  logic [ROOT_W-1:0]  sq_root_r;
  logic [SCNT_W-1:0]  sq_cnt_r;

  logic               div_neg_r;
  logic [DVD_W-1:0]   quo_r;
  logic [DVS_W-1:0]   rem_r, dvs_r;
  logic [DCNT_W-1:0]  div_cnt_r;

  logic signed [31:0] q_r, wr0_r, wr1_r, a_r, tmp_r;
  logic signed [17:0] c1_r, s1_r, cprev_r, sprev_r, cnew_r;
  logic signed [17:0] cs_r [MODES];
  logic signed [17:0] sn_r [MODES];
  logic [M_W-1:0]     m_r;
  logic               sub_r;
  logic [1:0]         k_r;
  logic signed [36:0] re_add_r, im_add_r;

  logic [31:0]        mem_re [DEPTH];
  logic [31:0]        mem_im [DEPTH];
  logic [31:0]        rd_re_r, rd_im_r;

  // datapath
  logic [R_W:0]              den;
  logic [R_W:0]              cr1;
  logic [2*R_W+1:0]          cr1_sq;
  logic signed [DVD_W-1:0]   div_num;
  logic [DVS_W-1:0]          div_dvs;
  logic [DVS_W:0]            div_shift;
  logic signed [DVD_W:0]     div_res;
  logic [ROOT_W+3:0]         sq_shift;
  logic [ROOT_W+1:0]         sq_trial;
  logic signed [47:0]        sq_prod;
  logic [47:0]               w_prod;
  logic signed [31:0]        wr0_sat;
  logic signed [36:0]        rc_diff, rs_sum;
  logic signed [17:0]        ccalc, scalc;
  logic [16:0]               wz;
  logic signed [31:0]        wr_sel;
  logic signed [48:0]        a_prod;
  logic signed [63:0]        t_prod;
  logic signed [49:0]        pc_prod, ps_prod;
  logic signed [63:0]        sum_re, sum_im;
  logic [ADDR_W-1:0]         corner_addr, rd_addr, wr_addr;
  logic                      we_re, we_im;
  logic [31:0]               wd_re, wd_im;

  assign den    = {item_r.cell_r, 1'b1};
  assign cr1    = {1'b0, item_r.cell_r} + (R_W+1)'(1);
  assign cr1_sq = cr1 * cr1;

  always_comb begin
    div_num = '0;
    div_dvs = '0;
    case (div_sel_r)
      DIV_Q: begin
        div_num = DVD_W'(wch_r);
        div_dvs = DVS_W'(den);
      end
      DIV_WR: begin
        div_num = $signed(DVD_W'(cr1_sq) << 32) - $signed(DVD_W'(r2_r));
        div_dvs = DVS_W'({den, 16'h0000});
      end
      DIV_C: begin
        div_num = $signed(DVD_W'(item_r.pos_x)) <<< 16;
        div_dvs = DVS_W'(sq_root_r);
      end
      DIV_S: begin
        div_num = $signed(DVD_W'(item_r.pos_y)) <<< 16;
        div_dvs = DVS_W'(sq_root_r);
      end
      default: begin
        div_num = '0;
        div_dvs = '0;
      end
    endcase
  end

  assign div_shift = {rem_r, quo_r[DVD_W-1]};
  assign div_res   = div_neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

  assign sq_shift = {sq_rem_r, sq_src_r[R2_W-1 -: 2]};
  assign sq_trial = {sq_root_r, 2'b01};

  assign sq_prod = (state_r == S_P0) ? item_r.pos_x * item_r.pos_x
                                     : item_r.pos_y * item_r.pos_y;
  assign w_prod  = item_r.particle_weight * dens_r[item_r.species];
  assign wr0_sat = sat32(64'(div_res));

  assign rc_diff = 37'(cprev_r * c1_r) - 37'(sprev_r * s1_r);
  assign rs_sum  = 37'(sprev_r * c1_r) + 37'(cprev_r * s1_r);
  assign ccalc   = clamp_unit(64'(rc_diff >>> 16));
  assign scalc   = clamp_unit(64'(rs_sum >>> 16));

  assign wz      = k_r[1] ? {1'b0, item_r.z_frac} : 17'h10000 - {1'b0, item_r.z_frac};
  assign wr_sel  = k_r[0] ? wr1_r : wr0_r;
  assign a_prod  = 49'(wr_sel) * $signed({32'd0, wz});
  assign t_prod  = 64'(a_r) * 64'(q_r);
  assign pc_prod = 50'(tmp_r) * 50'(cs_r[m_r]);
  assign ps_prod = 50'(tmp_r) * 50'(sn_r[m_r]);

  assign sum_re = 64'($signed(rd_re_r)) + 64'(re_add_r);
  assign sum_im = 64'($signed(rd_im_r)) + 64'(im_add_r);

  assign corner_addr = {m_r, Z_W'(item_r.cell_z + 7'(k_r[1])),
                        R_W'(item_r.cell_r + 6'(k_r[0]))};
  assign rd_addr = (state_r == S_RDA) ? {item_r.read_mode, item_r.cell_z, item_r.cell_r}
                                      : corner_addr;

  always_comb begin
    we_re   = 1'b0;
    we_im   = 1'b0;
    wr_addr = corner_addr;
    wd_re   = sat32(sum_re);
    wd_im   = sat32(sum_im);
    if (state_r == S_CLR) begin
      we_re   = 1'b1;
      we_im   = 1'b1;
      wr_addr = clr_cnt_r;
      wd_re   = '0;
      wd_im   = '0;
    end else if (state_r == S_WR) begin
      we_re = 1'b1;
      we_im = (m_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (we_re) begin
      mem_re[wr_addr] <= wd_re;
    end
    if (we_im) begin
      mem_im[wr_addr] <= wd_im;
    end
    rd_re_r <= mem_re[rd_addr];
    rd_im_r <= mem_im[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SPECIES; i++) begin
        dens_r[i] <= CFG_W'(DENS_RESET);
      end
    end else if (cfg_we) begin
      dens_r[cfg_idx] <= cfg_wdata;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      clr_res_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
          if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
            state_r <= clr_res_r ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item_r   <= in_data;
            res_re_r <= '0;
            res_im_r <= '0;
            res_st_r <= ST_OK;
            flag_r   <= 1'b0;
            case (in_data.func)
              FUNC_DEPOSIT: begin
                if (32'(in_data.cell_z) > GRID_Z - 2 || 32'(in_data.cell_r) > GRID_R - 2) begin
                  res_st_r <= ST_RANGE;
                  state_r  <= S_DONE;
                end else begin
                  state_r <= S_P0;
                end
              end
              FUNC_READ: begin
                if (32'(in_data.cell_z) >= GRID_Z || 32'(in_data.cell_r) >= GRID_R ||
                    32'(in_data.read_mode) >= MODES) begin
                  res_st_r <= ST_RANGE;
                  state_r  <= S_DONE;
                end else begin
                  state_r <= S_RDA;
                end
              end
              FUNC_CLEAR: begin
                clr_cnt_r <= '0;
                clr_res_r <= 1'b1;
                state_r   <= S_CLR;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_P0: begin
          r2_r    <= sq_prod[R2_W-1:0];
          state_r <= S_P1;
        end
        S_P1: begin
          r2_r    <= r2_r + sq_prod[R2_W-1:0];
          state_r <= S_P2;
        end
        S_P2: begin
          w_r      <= w_prod[47:16];
          sq_src_r <= r2_r;
          sq_rem_r <= '0;
          sq_root_r <= '0;
          sq_cnt_r <= '0;
          state_r  <= S_P3;
        end
        S_P3: begin
          wch_r   <= $signed({1'b0, w_r}) * item_r.charge;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          sq_src_r <= sq_src_r << 2;
          if (sq_shift >= {2'b00, sq_trial}) begin
            sq_rem_r  <= (ROOT_W+2)'(sq_shift - {2'b00, sq_trial});
            sq_root_r <= {sq_root_r[ROOT_W-2:0], 1'b1};
          end else begin
            sq_rem_r  <= sq_shift[ROOT_W+1:0];
            sq_root_r <= {sq_root_r[ROOT_W-2:0], 1'b0};
          end
          sq_cnt_r <= sq_cnt_r + SCNT_W'(1);
          if (sq_cnt_r == SCNT_W'(ROOT_W - 1)) begin
            div_sel_r <= DIV_Q;
            state_r   <= S_DLOAD;
          end
        end
        S_DLOAD: begin
          div_neg_r <= div_num[DVD_W-1];
          quo_r     <= div_num[DVD_W-1] ? DVD_W'(-div_num) : DVD_W'(div_num);
          rem_r     <= '0;
          dvs_r     <= div_dvs;
          div_cnt_r <= '0;
          state_r   <= S_DIV;
        end
        S_DIV: begin
          if (div_shift >= {1'b0, dvs_r}) begin
            rem_r <= DVS_W'(div_shift - {1'b0, dvs_r});
            quo_r <= {quo_r[DVD_W-2:0], 1'b1};
          end else begin
            rem_r <= div_shift[DVS_W-1:0];
            quo_r <= {quo_r[DVD_W-2:0], 1'b0};
          end
          div_cnt_r <= div_cnt_r + DCNT_W'(1);
          if (div_cnt_r == DCNT_W'(DVD_W - 1)) begin
            state_r <= S_DIVEND;
          end
        end
        S_DIVEND: begin
          case (div_sel_r)
            DIV_Q: begin
              q_r       <= sat32(64'(div_res));
              flag_r    <= flag_r | is_sat32(64'(div_res));
              div_sel_r <= DIV_WR;
              state_r   <= S_DLOAD;
            end
            DIV_WR: begin
              wr0_r  <= wr0_sat;
              wr1_r  <= sat32(64'sd65536 - 64'(wr0_sat));
              flag_r <= flag_r | is_sat32(64'(div_res)) |
                        is_sat32(64'sd65536 - 64'(wr0_sat));
              if (sq_root_r == '0) begin
                c1_r    <= 18'sd65536;
                s1_r    <= '0;
                state_r <= S_RECI;
              end else begin
                div_sel_r <= DIV_C;
                state_r   <= S_DLOAD;
              end
            end
            DIV_C: begin
              c1_r      <= clamp_unit(64'(div_res));
              div_sel_r <= DIV_S;
              state_r   <= S_DLOAD;
            end
            default: begin
              s1_r    <= clamp_unit(64'(div_res));
              state_r <= S_RECI;
            end
          endcase
        end
        S_RECI: begin
          cs_r[0] <= 18'sd65536;
          sn_r[0] <= '0;
          cs_r[1] <= c1_r;
          sn_r[1] <= s1_r;
          cprev_r <= c1_r;
          sprev_r <= s1_r;
          m_r     <= M_W'(2);
          sub_r   <= 1'b0;
          k_r     <= '0;
          state_r <= (MODES > 2) ? S_REC : S_CA;
        end
        S_REC: begin
          if (!sub_r) begin
            cnew_r <= ccalc;
            sub_r  <= 1'b1;
          end else begin
            cs_r[m_r] <= cnew_r;
            sn_r[m_r] <= scalc;
            cprev_r   <= cnew_r;
            sprev_r   <= scalc;
            sub_r     <= 1'b0;
            if (m_r == M_W'(MODES - 1)) begin
              state_r <= S_CA;
            end else begin
              m_r <= m_r + M_W'(1);
            end
          end
        end
        S_CA: begin
          a_r     <= sat32(64'(a_prod >>> 16));
          flag_r  <= flag_r | is_sat32(64'(a_prod >>> 16));
          state_r <= S_CT;
        end
        S_CT: begin
          tmp_r   <= sat32(t_prod >>> 16);
          flag_r  <= flag_r | is_sat32(t_prod >>> 16);
          m_r     <= '0;
          state_r <= S_RD;
        end
        S_RD: begin
          if (m_r == '0) begin
            re_add_r <= 37'(tmp_r);
            im_add_r <= '0;
          end else begin
            re_add_r <= 37'(pc_prod >>> 15);
            im_add_r <= -37'(ps_prod >>> 15);
          end
          state_r <= S_WR;
        end
        S_WR: begin
          flag_r <= flag_r | is_sat32(sum_re) | ((m_r != '0) & is_sat32(sum_im));
          if (m_r == M_W'(MODES - 1)) begin
            m_r <= '0;
            if (k_r == 2'd3) begin
              res_st_r <= (flag_r | is_sat32(sum_re) | is_sat32(sum_im)) ? ST_SAT : ST_OK;
              state_r  <= S_DONE;
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= S_CA;
            end
          end else begin
            m_r     <= m_r + M_W'(1);
            state_r <= S_RD;
          end
        end
        S_RDA: begin
          state_r <= S_RDB;
        end
        S_RDB: begin
          res_re_r <= rd_re_r;
          res_im_r <= rd_im_r;
          state_r  <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r         <= 1'b1;
            out_data_r.rho_real <= res_re_r;
            out_data_r.rho_imag <= res_im_r;
            out_data_r.status   <= res_st_r;
            clr_res_r           <= 1'b0;
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
